// ===== rtl/core/wvp_pkg.sv =====
// wvp_pkg: shared constants, widths and codes of the wireframe vertex projector
// used by the channel interfaces, the cordic lanes, the divider and the top level
// no dependencies
package wvp_pkg;

  // sizing of the algorithm
  localparam int CORDIC_STEPS = 16;
  localparam int SCREEN_BITS  = 12;
  localparam int TABLE_LEN    = 20;

  // field widths
  localparam int AW     = 16;  // angle, degrees Q8.7
  localparam int CW     = 16;  // coordinate, Q4.12
  localparam int TW     = 16;  // sine and cosine, Q1.14
  localparam int OW     = 10;  // screen origin
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  // cordic datapath
  localparam int XW = 32;      // x and y in Q.28
  localparam int ZW = 26;      // residual angle, degrees Q.16
  localparam logic signed [XW-1:0] GAIN_Q28  = 32'sd163008219;
  localparam logic signed [16:0]   DEG180_Q7 = 17'sd23040;
  localparam logic signed [16:0]   DEG360_Q7 = 17'sd46080;
  localparam logic signed [16:0]   DEG90_Q7  = 17'sd11520;
  localparam logic signed [TW-1:0] TRIG_ONE  = 16'sd16384;
  localparam int TRIG_FRAC = 14;

  // arctangent of 2^-i in degrees Q.16
  localparam logic signed [ZW-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379,
    26'sd117304,  26'sd58666,   26'sd29335,  26'sd14668,  26'sd7334,
    26'sd3667,    26'sd1833,    26'sd917,    26'sd458,    26'sd229,
    26'sd115,     26'sd57,      26'sd29,     26'sd14,     26'sd7
  };

  // vertex datapath
  localparam int VW    = CW + 1;        // centred coordinate
  localparam int PRW   = VW + TW + 1;   // rotation product
  localparam int SUMW  = PRW + 1;       // sum of two products
  localparam int RTW   = VW + 1;        // after first rotation
  localparam int R2W   = RTW + 1;       // after second rotation
  localparam int MAGW  = R2W - 1;       // magnitude of a rotated coordinate
  localparam int KW    = 32;            // scale_factor * view_depth
  localparam int MW    = MAGW + KW;     // magnitude times scale
  localparam int M20W  = MW + 5;        // times twenty
  localparam int FRAC  = 18;            // 2^18 folded into the divisor
  localparam int NW    = M20W - FRAC;   // dividend
  localparam int DENW  = 25;            // signed denominator
  localparam int DW    = DENW - 1;      // positive denominator
  localparam int QB    = SCREEN_BITS + 2;
  localparam int RW    = DW + QB;
  localparam int PW    = QB + 2;        // unsaturated pixel

  localparam logic signed [PW-1:0] SMAX_P = PW'((1 << (SCREEN_BITS - 1)) - 1);
  localparam logic signed [PW-1:0] SMIN_P = -PW'(1 << (SCREEN_BITS - 1));

  // action codes
  localparam logic ACT_ATTITUDE = 1'b0;
  localparam logic ACT_VERTEX   = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_CENTER_X     = 3'd0,
    CFG_CENTER_Y     = 3'd1,
    CFG_CENTER_Z     = 3'd2,
    CFG_SCALE_FACTOR = 3'd3,
    CFG_VIEW_DEPTH   = 3'd4,
    CFG_ORIGIN_X     = 3'd5,
    CFG_ORIGIN_Y     = 3'd6
  } cfg_idx_e;

endpackage

// ===== rtl/core/wvp_if.sv =====
// wvp_if: valid/ready channel interfaces of the projector
// input items, result items and the configuration write channel; uses wvp_pkg
interface wvp_in_if;
  logic                            valid;
  logic                            ready;
  logic                            action;
  logic signed [wvp_pkg::AW-1:0]   roll_angle;
  logic signed [wvp_pkg::AW-1:0]   pitch_angle;
  logic signed [wvp_pkg::CW-1:0]   vertex_x;
  logic signed [wvp_pkg::CW-1:0]   vertex_y;
  logic signed [wvp_pkg::CW-1:0]   vertex_z;

  modport source (output valid, action, roll_angle, pitch_angle, vertex_x, vertex_y,
                  vertex_z, input ready);
  modport sink (input valid, action, roll_angle, pitch_angle, vertex_x, vertex_y,
                vertex_z, output ready);
endinterface

interface wvp_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [wvp_pkg::SCREEN_BITS-1:0] screen_x;
  logic signed [wvp_pkg::SCREEN_BITS-1:0] screen_y;
  logic                                   clipped;

  modport source (output valid, screen_x, screen_y, clipped, input ready);
  modport sink (input valid, screen_x, screen_y, clipped, output ready);
endinterface

interface wvp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wvp_pkg::CFG_IW-1:0]    index;
  logic [wvp_pkg::CFG_DW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/wireframe_vertex_projector.sv =====
// Wireframe vertex projector. One input transaction is taken per clock cycle unless a result
// waits at the output, attitude and vertex items alike. A vertex result passes through the
// pipeline: CORDIC_STEPS + 2 cordic stages, six rotation and scaling stages, SCREEN_BITS + 3
// divider stages (an overflow check and one stage per quotient bit) and the output register.
// Attitude items run through the same pipeline, so a vertex right behind an attitude item
// already sees the new angles. The whole pipeline holds while a result waits at the output;
// configuration is taken at any time with ready always high.
module wireframe_vertex_projector (
  input  logic       clk_i,
  input  logic       rst_ni,
  wvp_cfg_if.sink    cfg_i,
  wvp_in_if.sink     in_i,
  wvp_out_if.source  out_o
);
  import wvp_pkg::*;

  localparam int CL = CORDIC_STEPS + 2;
  localparam int DL = QB + 1;

  // configuration registers
  logic signed [CW-1:0] cx_q, cy_q, cz_q;
  logic [15:0]          sf_q, vd_q;
  logic [OW-1:0]        ox_q, oy_q;
  logic [KW-1:0]        kp_q;

  // trig state
  logic signed [TW-1:0] sin_roll_q, cos_roll_q, sin_pitch_q, cos_pitch_q;
  logic signed [TW-1:0] sin_roll_c, cos_roll_c, sin_pitch_c, cos_pitch_c;
  logic                 trig_we;

  // pipeline control
  logic adv;

  // entry line, aligned with the cordic lanes
  logic                 lv_q [CL];
  logic                 la_q [CL];
  logic signed [VW-1:0] lx_q [CL];
  logic signed [VW-1:0] ly_q [CL];
  logic signed [VW-1:0] lz_q [CL];

  // rotation and scaling stages
  logic                  r1v_q, r1a_q, r2v_q, r2a_q, r3v_q, r3a_q;
  logic                  r4v_q, r4a_q, r5v_q, r5a_q, r6v_q, r6a_q;
  logic signed [VW-1:0]  r1x_q, r2x_q;
  logic signed [PRW-1:0] r1p_q [4];
  logic signed [PRW-1:0] r3p_q [4];
  logic signed [RTW-1:0] r2y_q, r2z_q;
  logic signed [TW-1:0]  r2sp_q, r2cp_q;
  logic signed [DENW-1:0] r3den_q, r4den_q;
  logic signed [R2W-1:0] r4x_q, r4y_q;
  logic [MW-1:0]         r5mx_q, r5my_q;
  logic                  r5sx_q, r5sy_q, r5pos_q;
  logic [DW-1:0]         r5d_q, r6d_q;
  logic [NW-1:0]         r6nx_q, r6ny_q;
  logic                  r6sx_q, r6sy_q, r6pos_q;
  logic                  r6zx_q, r6zy_q, r6lx_q, r6ly_q;

  logic signed [SUMW-1:0] s_y1, s_z1, s_x2, s_y2;
  logic signed [RTW-1:0]  y1_c, z1_c;
  logic signed [R2W-1:0]  x2_c, y2_c, ax_c, ay_c;
  logic signed [DENW-1:0] den_c;
  logic [M20W-1:0]        m20x, m20y;

  // divider side line
  logic dv_q [DL];
  logic da_q [DL];
  logic dsx_q [DL];
  logic dsy_q [DL];
  logic dpos_q [DL];
  logic dzx_q [DL];
  logic dzy_q [DL];
  logic dlx_q [DL];
  logic dly_q [DL];
  logic [QB-1:0] qx, qy;
  logic          ovfx, ovfy, rnzx, rnzy;

  // final stage
  logic signed [PW-1:0]          px, py;
  logic [QB-1:0]                 qxs, qys;
  logic                          fin_clip, fin_valid;
  logic signed [SCREEN_BITS-1:0] sx_d, sy_d;
  logic                          clip_d;

  // output register
  logic                          ov_q;
  logic signed [SCREEN_BITS-1:0] osx_q, osy_q;
  logic                          oclip_q;

  assign adv         = !ov_q || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      sf_q <= 16'd256;
      vd_q <= 16'd1024;
      ox_q <= '0;
      oy_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_CENTER_X:     cx_q <= cfg_i.data;
        CFG_CENTER_Y:     cy_q <= cfg_i.data;
        CFG_CENTER_Z:     cz_q <= cfg_i.data;
        CFG_SCALE_FACTOR: sf_q <= cfg_i.data;
        CFG_VIEW_DEPTH:   vd_q <= cfg_i.data;
        CFG_ORIGIN_X:     ox_q <= cfg_i.data[OW-1:0];
        CFG_ORIGIN_Y:     oy_q <= cfg_i.data[OW-1:0];
        default: ;
      endcase
    end
  end

  // scale product follows the configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= KW'(256 * 1024);
    end else begin
      kp_q <= KW'(sf_q) * KW'(vd_q);
    end
  end

  // sine and cosine lanes
  wvp_cordic u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .angle_i (in_i.roll_angle),
    .sin_o   (sin_roll_c),
    .cos_o   (cos_roll_c)
  );

  wvp_cordic u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .angle_i (in_i.pitch_angle),
    .sin_o   (sin_pitch_c),
    .cos_o   (cos_pitch_c)
  );

  // attitude items update the trig state as they leave the cordic stages
  assign trig_we = adv && lv_q[CL-1] && (la_q[CL-1] == ACT_ATTITUDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_roll_q  <= '0;
      cos_roll_q  <= TRIG_ONE;
      sin_pitch_q <= '0;
      cos_pitch_q <= TRIG_ONE;
    end else if (trig_we) begin
      sin_roll_q  <= sin_roll_c;
      cos_roll_q  <= cos_roll_c;
      sin_pitch_q <= sin_pitch_c;
      cos_pitch_q <= cos_pitch_c;
    end
  end

  // entry line: centre the vertex, then wait for the cordic
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CL; i++) begin
        lv_q[i] <= 1'b0;
        la_q[i] <= 1'b0;
        lx_q[i] <= '0;
        ly_q[i] <= '0;
        lz_q[i] <= '0;
      end
    end else if (adv) begin
      lv_q[0] <= in_i.valid;
      la_q[0] <= in_i.action;
      lx_q[0] <= VW'(in_i.vertex_x) - VW'(cx_q);
      ly_q[0] <= VW'(in_i.vertex_y) - VW'(cy_q);
      lz_q[0] <= VW'(in_i.vertex_z) - VW'(cz_q);
      for (int i = 1; i < CL; i++) begin
        lv_q[i] <= lv_q[i-1];
        la_q[i] <= la_q[i-1];
        lx_q[i] <= lx_q[i-1];
        ly_q[i] <= ly_q[i-1];
        lz_q[i] <= lz_q[i-1];
      end
    end
  end

  // rounding sums and scaling terms
  always_comb begin
    s_y1  = SUMW'(r1p_q[0]) - SUMW'(r1p_q[1]) + SUMW'(1 << (TRIG_FRAC - 1));
    s_z1  = SUMW'(r1p_q[2]) + SUMW'(r1p_q[3]) + SUMW'(1 << (TRIG_FRAC - 1));
    y1_c  = RTW'(s_y1 >>> TRIG_FRAC);
    z1_c  = RTW'(s_z1 >>> TRIG_FRAC);
    s_x2  = SUMW'(r3p_q[0]) - SUMW'(r3p_q[1]) + SUMW'(1 << (TRIG_FRAC - 1));
    s_y2  = SUMW'(r3p_q[2]) + SUMW'(r3p_q[3]) + SUMW'(1 << (TRIG_FRAC - 1));
    x2_c  = R2W'(s_x2 >>> TRIG_FRAC);
    y2_c  = R2W'(s_y2 >>> TRIG_FRAC);
    den_c = DENW'($signed({1'b0, vd_q})) * DENW'(92) + DENW'(r2z_q) * DENW'(20);
    ax_c  = r4x_q[R2W-1] ? -r4x_q : r4x_q;
    ay_c  = r4y_q[R2W-1] ? -r4y_q : r4y_q;
    m20x  = (M20W'(r5mx_q) << 4) + (M20W'(r5mx_q) << 2);
    m20y  = (M20W'(r5my_q) << 4) + (M20W'(r5my_q) << 2);
  end

  // rotate about x by roll, about the view axis by pitch, then scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1v_q <= 1'b0; r1a_q <= 1'b0; r2v_q <= 1'b0; r2a_q <= 1'b0;
      r3v_q <= 1'b0; r3a_q <= 1'b0; r4v_q <= 1'b0; r4a_q <= 1'b0;
      r5v_q <= 1'b0; r5a_q <= 1'b0; r6v_q <= 1'b0; r6a_q <= 1'b0;
      r1x_q <= '0; r2x_q <= '0; r2y_q <= '0; r2z_q <= '0;
      r2sp_q <= '0; r2cp_q <= '0;
      for (int i = 0; i < 4; i++) begin
        r1p_q[i] <= '0;
        r3p_q[i] <= '0;
      end
      r3den_q <= '0; r4den_q <= '0; r4x_q <= '0; r4y_q <= '0;
      r5mx_q <= '0; r5my_q <= '0; r5sx_q <= 1'b0; r5sy_q <= 1'b0;
      r5pos_q <= 1'b0; r5d_q <= '0;
      r6nx_q <= '0; r6ny_q <= '0; r6sx_q <= 1'b0; r6sy_q <= 1'b0;
      r6pos_q <= 1'b0; r6d_q <= '0;
      r6zx_q <= 1'b0; r6zy_q <= 1'b0; r6lx_q <= 1'b0; r6ly_q <= 1'b0;
    end else if (adv) begin
      // products of the roll rotation
      r1v_q    <= lv_q[CL-1];
      r1a_q    <= la_q[CL-1];
      r1x_q    <= lx_q[CL-1];
      r1p_q[0] <= PRW'(ly_q[CL-1]) * PRW'(cos_roll_q);
      r1p_q[1] <= PRW'(lz_q[CL-1]) * PRW'(sin_roll_q);
      r1p_q[2] <= PRW'(ly_q[CL-1]) * PRW'(sin_roll_q);
      r1p_q[3] <= PRW'(lz_q[CL-1]) * PRW'(cos_roll_q);
      // round back to Q4.12, keep the pitch seen by this item
      r2v_q  <= r1v_q;
      r2a_q  <= r1a_q;
      r2x_q  <= r1x_q;
      r2y_q  <= y1_c;
      r2z_q  <= z1_c;
      r2sp_q <= sin_pitch_q;
      r2cp_q <= cos_pitch_q;
      // products of the pitch rotation and the denominator
      r3v_q    <= r2v_q;
      r3a_q    <= r2a_q;
      r3p_q[0] <= PRW'(r2x_q) * PRW'(r2cp_q);
      r3p_q[1] <= PRW'(r2y_q) * PRW'(r2sp_q);
      r3p_q[2] <= PRW'(r2x_q) * PRW'(r2sp_q);
      r3p_q[3] <= PRW'(r2y_q) * PRW'(r2cp_q);
      r3den_q  <= den_c;
      // round back to Q4.12
      r4v_q   <= r3v_q;
      r4a_q   <= r3a_q;
      r4x_q   <= x2_c;
      r4y_q   <= y2_c;
      r4den_q <= r3den_q;
      // magnitude times scale_factor * view_depth
      r5v_q   <= r4v_q;
      r5a_q   <= r4a_q;
      r5mx_q  <= MW'(ax_c[MAGW-1:0]) * MW'(kp_q);
      r5my_q  <= MW'(ay_c[MAGW-1:0]) * MW'(kp_q);
      r5sx_q  <= r4x_q[R2W-1];
      r5sy_q  <= r4y_q[R2W-1];
      r5pos_q <= r4den_q > DENW'(0);
      r5d_q   <= r4den_q[DW-1:0];
      // times twenty, split off the 2^18 of the divisor
      r6v_q   <= r5v_q;
      r6a_q   <= r5a_q;
      r6nx_q  <= m20x[M20W-1:FRAC];
      r6ny_q  <= m20y[M20W-1:FRAC];
      r6lx_q  <= |m20x[FRAC-1:0];
      r6ly_q  <= |m20y[FRAC-1:0];
      r6zx_q  <= (r5mx_q == '0);
      r6zy_q  <= (r5my_q == '0);
      r6sx_q  <= r5sx_q;
      r6sy_q  <= r5sy_q;
      r6pos_q <= r5pos_q;
      r6d_q   <= r5d_q;
    end
  end

  // perspective division of both coordinates
  wvp_divider u_div_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .n_i      (r6nx_q),
    .d_i      (r6d_q),
    .q_o      (qx),
    .ovf_o    (ovfx),
    .rem_nz_o (rnzx)
  );

  wvp_divider u_div_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .n_i      (r6ny_q),
    .d_i      (r6d_q),
    .q_o      (qy),
    .ovf_o    (ovfy),
    .rem_nz_o (rnzy)
  );

  // flags that travel beside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DL; i++) begin
        dv_q[i] <= 1'b0; da_q[i] <= 1'b0; dsx_q[i] <= 1'b0; dsy_q[i] <= 1'b0;
        dpos_q[i] <= 1'b0; dzx_q[i] <= 1'b0; dzy_q[i] <= 1'b0;
        dlx_q[i] <= 1'b0; dly_q[i] <= 1'b0;
      end
    end else if (adv) begin
      dv_q[0]   <= r6v_q;
      da_q[0]   <= r6a_q;
      dsx_q[0]  <= r6sx_q;
      dsy_q[0]  <= r6sy_q;
      dpos_q[0] <= r6pos_q;
      dzx_q[0]  <= r6zx_q;
      dzy_q[0]  <= r6zy_q;
      dlx_q[0]  <= r6lx_q;
      dly_q[0]  <= r6ly_q;
      for (int i = 1; i < DL; i++) begin
        dv_q[i]   <= dv_q[i-1];
        da_q[i]   <= da_q[i-1];
        dsx_q[i]  <= dsx_q[i-1];
        dsy_q[i]  <= dsy_q[i-1];
        dpos_q[i] <= dpos_q[i-1];
        dzx_q[i]  <= dzx_q[i-1];
        dzy_q[i]  <= dzy_q[i-1];
        dlx_q[i]  <= dlx_q[i-1];
        dly_q[i]  <= dly_q[i-1];
      end
    end
  end

  // origin plus or minus the quotient, truncated toward zero
  function automatic logic signed [PW-1:0] place(logic [OW-1:0] o, logic [QB-1:0] q,
                                                  logic up, logic rnz);
    logic signed [PW-1:0] t;
    t = PW'(o);
    if (up) begin
      t = t + PW'(q);
    end else begin
      t = t - PW'(q);
      if (rnz && t > 0) t = t - PW'(1);
    end
    return t;
  endfunction

  // pixel placement and saturation
  always_comb begin
    qxs       = ovfx ? '1 : qx;
    qys       = ovfy ? '1 : qy;
    fin_valid = dv_q[DL-1] && (da_q[DL-1] == ACT_VERTEX);
    fin_clip  = !dpos_q[DL-1];
    if (dpos_q[DL-1]) begin
      px = place(ox_q, qxs, !dsx_q[DL-1], rnzx || dlx_q[DL-1]);
      py = place(oy_q, qys, dsy_q[DL-1], rnzy || dly_q[DL-1]);
    end else begin
      px = dzx_q[DL-1] ? PW'(ox_q) : (dsx_q[DL-1] ? SMIN_P : SMAX_P);
      py = dzy_q[DL-1] ? PW'(oy_q) : (dsy_q[DL-1] ? SMAX_P : SMIN_P);
    end
    clip_d = fin_clip;
    sx_d   = px[SCREEN_BITS-1:0];
    sy_d   = py[SCREEN_BITS-1:0];
    if (px > SMAX_P) begin
      sx_d = SMAX_P[SCREEN_BITS-1:0];
      clip_d = 1'b1;
    end else if (px < SMIN_P) begin
      sx_d = SMIN_P[SCREEN_BITS-1:0];
      clip_d = 1'b1;
    end
    if (py > SMAX_P) begin
      sy_d = SMAX_P[SCREEN_BITS-1:0];
      clip_d = 1'b1;
    end else if (py < SMIN_P) begin
      sy_d = SMIN_P[SCREEN_BITS-1:0];
      clip_d = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      osx_q   <= '0;
      osy_q   <= '0;
      oclip_q <= 1'b0;
    end else if (adv) begin
      ov_q    <= fin_valid;
      osx_q   <= sx_d;
      osy_q   <= sy_d;
      oclip_q <= clip_d;
    end
  end

  assign out_o.valid    = ov_q;
  assign out_o.screen_x = osx_q;
  assign out_o.screen_y = osy_q;
  assign out_o.clipped  = oclip_q;

`ifndef SYNTH
  // trig state moves only when an attitude item leaves the cordic stages
  a_trig_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!$stable(sin_roll_q) || !$stable(cos_pitch_q)) |-> $past(trig_we))
    else $error("trig state changed without an attitude item");

  // a non-positive denominator always reports a clipped result
  a_den_clip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && fin_valid && !dpos_q[DL-1]) |=> (out_o.valid && out_o.clipped))
    else $error("non-positive denominator not clipped");

  // a result only appears on a pipeline advance
  a_out_adv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(adv))
    else $error("result appeared while the pipeline was held");
`endif

endmodule

// ===== rtl/core/wvp_cordic.sv =====
// wvp_cordic: pipelined rotation-mode cordic, one step per stage
// degrees Q8.7 in, registered sine and cosine Q1.14 out; stages advance on en_i; uses wvp_pkg
module wvp_cordic (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic signed [wvp_pkg::AW-1:0] angle_i,
  output logic signed [wvp_pkg::TW-1:0] sin_o,
  output logic signed [wvp_pkg::TW-1:0] cos_o
);
  import wvp_pkg::*;

  logic signed [XW-1:0] x_q [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_q [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_q [CORDIC_STEPS+1];
  logic                 neg_q [CORDIC_STEPS+1];
  logic signed [16:0]   a_wrap;
  logic signed [16:0]   a_fold;
  logic                 neg_d;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] yr;
  logic signed [XW-1:0] xc;
  logic signed [XW-1:0] yc;
  logic signed [TW-1:0] sin_q;
  logic signed [TW-1:0] cos_q;

  // wrap to +-180 and fold into +-90
  always_comb begin
    a_wrap = {angle_i[AW-1], angle_i};
    if (a_wrap > DEG180_Q7) begin
      a_wrap = a_wrap - DEG360_Q7;
    end
    if (a_wrap < -DEG180_Q7) begin
      a_wrap = a_wrap + DEG360_Q7;
    end
    a_fold = a_wrap;
    neg_d  = 1'b0;
    if (a_wrap > DEG90_Q7) begin
      a_fold = a_wrap - DEG180_Q7;
      neg_d  = 1'b1;
    end else if (a_wrap < -DEG90_Q7) begin
      a_fold = a_wrap + DEG180_Q7;
      neg_d  = 1'b1;
    end
  end

  // initial vector
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q[0]   <= '0;
      y_q[0]   <= '0;
      z_q[0]   <= '0;
      neg_q[0] <= 1'b0;
    end else if (en_i) begin
      x_q[0]   <= GAIN_Q28;
      y_q[0]   <= '0;
      z_q[0]   <= ZW'(a_fold) <<< 9;
      neg_q[0] <= neg_d;
    end
  end

  // one micro-rotation per stage
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = y_q[k] >>> k;
    assign dy = x_q[k] >>> k;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        x_q[k+1]   <= '0;
        y_q[k+1]   <= '0;
        z_q[k+1]   <= '0;
        neg_q[k+1] <= 1'b0;
      end else if (en_i) begin
        neg_q[k+1] <= neg_q[k];
        if (!z_q[k][ZW-1]) begin
          x_q[k+1] <= x_q[k] - dx;
          y_q[k+1] <= y_q[k] + dy;
          z_q[k+1] <= z_q[k] - ATAN_DEG_Q16[k];
        end else begin
          x_q[k+1] <= x_q[k] + dx;
          y_q[k+1] <= y_q[k] - dy;
          z_q[k+1] <= z_q[k] + ATAN_DEG_Q16[k];
        end
      end
    end
  end

  // round half up to Q1.14, clamp, undo the fold
  always_comb begin
    xr = (x_q[CORDIC_STEPS] + XW'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    yr = (y_q[CORDIC_STEPS] + XW'(1 << (TRIG_FRAC - 1))) >>> TRIG_FRAC;
    xc = xr;
    yc = yr;
    if (xr > XW'(TRIG_ONE)) xc = XW'(TRIG_ONE);
    if (xr < -XW'(TRIG_ONE)) xc = -XW'(TRIG_ONE);
    if (yr > XW'(TRIG_ONE)) yc = XW'(TRIG_ONE);
    if (yr < -XW'(TRIG_ONE)) yc = -XW'(TRIG_ONE);
    if (neg_q[CORDIC_STEPS]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_q <= '0;
      cos_q <= TRIG_ONE;
    end else if (en_i) begin
      sin_q <= yc[TW-1:0];
      cos_q <= xc[TW-1:0];
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

`ifndef SYNTH
  // results never leave the unit circle bounds
  a_cos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (cos_o <= TRIG_ONE && cos_o >= -TRIG_ONE && sin_o <= TRIG_ONE &&
              sin_o >= -TRIG_ONE))
    else $error("cordic output outside +-1");
`endif

endmodule

// ===== rtl/core/wvp_divider.sv =====
// wvp_divider: pipelined restoring divider, one quotient bit per stage
// gives QB quotient bits, an overflow flag and a nonzero remainder flag; uses wvp_pkg
module wvp_divider (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic [wvp_pkg::NW-1:0]   n_i,
  input  logic [wvp_pkg::DW-1:0]   d_i,
  output logic [wvp_pkg::QB-1:0]   q_o,
  output logic                     ovf_o,
  output logic                     rem_nz_o
);
  import wvp_pkg::*;

  logic [RW-1:0] r_q   [QB+1];
  logic [DW-1:0] d_q   [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic          ovf_q [QB+1];

  // quotient too large for QB bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q[0]   <= '0;
      d_q[0]   <= '0;
      q_q[0]   <= '0;
      ovf_q[0] <= 1'b0;
    end else if (en_i) begin
      r_q[0]   <= RW'(n_i);
      d_q[0]   <= d_i;
      q_q[0]   <= '0;
      ovf_q[0] <= RW'(n_i) >= (RW'(d_i) << QB);
    end
  end

  // trial subtract, most significant bit first
  for (genvar j = 1; j <= QB; j++) begin : g_bit
    logic [RW-1:0] dsh;
    assign dsh = RW'(d_q[j-1]) << (QB - j);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        r_q[j]   <= '0;
        d_q[j]   <= '0;
        q_q[j]   <= '0;
        ovf_q[j] <= 1'b0;
      end else if (en_i) begin
        d_q[j]   <= d_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        if (r_q[j-1] >= dsh) begin
          r_q[j] <= r_q[j-1] - dsh;
          q_q[j] <= q_q[j-1] | (QB'(1) << (QB - j));
        end else begin
          r_q[j] <= r_q[j-1];
          q_q[j] <= q_q[j-1];
        end
      end
    end
  end

  assign q_o      = q_q[QB];
  assign ovf_o    = ovf_q[QB];
  assign rem_nz_o = |r_q[QB];

`ifndef SYNTH
  // without overflow the remainder ends below a nonzero divisor
  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ovf_q[QB] && d_q[QB] != '0) |-> (r_q[QB] < RW'(d_q[QB])))
    else $error("divider remainder not reduced");
`endif

endmodule
